/* src/tks_pkg.sv */
`default_nettype none

package tks_pkg;

    // Longest blob accepted before the scan reports too long
    localparam int MAX_BLOB_BYTES = 65536;
    // Position counter wide enough to hold MAX_BLOB_BYTES itself
    localparam int POS_W = $clog2(MAX_BLOB_BYTES + 1);

    localparam int DATA_W   = 8;
    localparam int OFFSET_W = 16;
    localparam int STATUS_W = 2;

    // Parse phase codes
    localparam logic [1:0] PH_KEY = 2'd0;
    localparam logic [1:0] PH_LEN = 2'd1;
    localparam logic [1:0] PH_VAL = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MALFORMED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TOOLONG   = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic [DATA_W-1:0] search_key;
        logic              blob_end;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFFSET_W-1:0] record_offset;
        logic [DATA_W-1:0]   value_length;
    } t_result;

endpackage

`default_nettype wire

/* src/tks_if.sv */
`default_nettype none

// Input channel: one blob byte per word
interface tks_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [7:0] search_key;
    logic       blob_end;

    modport source (output valid, output data_byte, output search_key, output blob_end,
                    input ready);
    modport sink   (input valid, input data_byte, input search_key, input blob_end,
                    output ready);
endinterface

// Result channel: one word per blob
interface tks_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] record_offset;
    logic [7:0]  value_length;

    modport source (output valid, output status, output record_offset, output value_length,
                    input ready);
    modport sink   (input valid, input status, input record_offset, input value_length,
                    output ready);
endinterface

`default_nettype wire

/* src/tks_in_stage.sv */
`default_nettype none

module tks_in_stage (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  tks_pkg::t_in_word i_word,
    input  wire               i_take,
    output logic              o_ready,
    output logic              o_valid,
    output tks_pkg::t_in_word o_word
);
    import tks_pkg::*;

    logic     r_valid;
    t_in_word r_word;

    // Accept a new word when empty or when the held word moves on this cycle
    assign o_ready = !r_valid || i_take;

    // Hold valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;
endmodule

`default_nettype wire

/* src/tks_parser.sv */
`default_nettype none

module tks_parser (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_fire,
    input  tks_pkg::t_in_word i_word,
    output tks_pkg::t_result  o_result
);
    import tks_pkg::*;

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_BLOB_BYTES);

    logic [POS_W-1:0]    r_byte_position, n_byte_position;
    logic [1:0]          r_parse_phase,   n_parse_phase;
    logic [DATA_W-1:0]   r_bytes_left,    n_bytes_left;
    logic [OFFSET_W-1:0] r_entry_start,   n_entry_start;
    logic                r_entry_matches, n_entry_matches;
    logic [DATA_W-1:0]   r_held_key,      n_held_key;
    logic                r_match_locked,  n_match_locked;
    logic [OFFSET_W-1:0] r_match_offset,  n_match_offset;
    logic [DATA_W-1:0]   r_match_length,  n_match_length;
    logic                r_overflowed,    n_overflowed;

    logic [DATA_W-1:0]   key;
    logic [DATA_W-1:0]   left_dec;

    // Advance the record parse for one byte
    always_comb begin
        n_byte_position = r_byte_position;
        n_parse_phase   = r_parse_phase;
        n_bytes_left    = r_bytes_left;
        n_entry_start   = r_entry_start;
        n_entry_matches = r_entry_matches;
        n_held_key      = (r_byte_position == '0) ? i_word.search_key : r_held_key;
        n_match_locked  = r_match_locked;
        n_match_offset  = r_match_offset;
        n_match_length  = r_match_length;
        n_overflowed    = r_overflowed;
        key             = n_held_key;
        left_dec        = (r_bytes_left != '0) ? r_bytes_left - 1'b1 : r_bytes_left;

        // Saturate position and flag overflow
        if (r_byte_position >= MAX_POS) begin
            n_overflowed = 1'b1;
        end else begin
            n_byte_position = r_byte_position + 1'b1;
        end

        // Stop parsing once a match has completed
        if (!r_match_locked) begin
            unique case (r_parse_phase)
                PH_KEY: begin
                    n_entry_start   = OFFSET_W'(r_byte_position);
                    n_entry_matches = (i_word.data_byte == key);
                    n_parse_phase   = PH_LEN;
                end
                PH_LEN: begin
                    n_bytes_left = i_word.data_byte;
                    if (r_entry_matches) begin
                        n_match_length = i_word.data_byte;
                    end
                    if (i_word.data_byte == '0) begin
                        if (r_entry_matches) begin
                            n_match_locked = 1'b1;
                            n_match_offset = r_entry_start;
                        end
                        n_parse_phase = PH_KEY;
                    end else begin
                        n_parse_phase = PH_VAL;
                    end
                end
                default: begin
                    n_bytes_left = left_dec;
                    if (left_dec == '0) begin
                        if (r_entry_matches) begin
                            n_match_locked = 1'b1;
                            n_match_offset = r_entry_start;
                        end
                        n_parse_phase = PH_KEY;
                    end
                end
            endcase
        end
    end

    // Form the blob verdict from the updated state
    always_comb begin
        o_result = '0;
        if (n_overflowed) begin
            o_result.status = ST_TOOLONG;
        end else if (n_match_locked) begin
            o_result.status        = ST_FOUND;
            o_result.record_offset = n_match_offset;
            o_result.value_length  = n_match_length;
        end else if (n_parse_phase == PH_VAL) begin
            o_result.status = ST_MALFORMED;
        end else begin
            o_result.status = ST_NOTFOUND;
        end
    end

    // Update state; clear it after the last byte of a blob
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_word.blob_end)) begin
            r_byte_position <= '0;
            r_parse_phase   <= PH_KEY;
            r_bytes_left    <= '0;
            r_entry_start   <= '0;
            r_entry_matches <= 1'b0;
            r_held_key      <= '0;
            r_match_locked  <= 1'b0;
            r_match_offset  <= '0;
            r_match_length  <= '0;
            r_overflowed    <= 1'b0;
        end else if (i_fire) begin
            r_byte_position <= n_byte_position;
            r_parse_phase   <= n_parse_phase;
            r_bytes_left    <= n_bytes_left;
            r_entry_start   <= n_entry_start;
            r_entry_matches <= n_entry_matches;
            r_held_key      <= n_held_key;
            r_match_locked  <= n_match_locked;
            r_match_offset  <= n_match_offset;
            r_match_length  <= n_match_length;
            r_overflowed    <= n_overflowed;
        end
    end
endmodule

`default_nettype wire

/* src/tks_out_stage.sv */
`default_nettype none

module tks_out_stage (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_load,
    input  tks_pkg::t_result i_result,
    input  wire              i_ready,
    output logic             o_free,
    output logic             o_valid,
    output tks_pkg::t_result o_result
);
    import tks_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Room for a new word when empty or when the held word leaves
    assign o_free = !r_valid || i_ready;

    // Hold valid until the word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Capture result
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
endmodule

`default_nettype wire

/* src/tlv_key_scanner_top.sv */
`default_nettype none

// TLV key scanner. Takes a blob of key/length/value records one byte per word
// and, on the word that carries blob_end, returns one result word: found with
// the offset and length byte of the first complete matching record, not found,
// malformed, or too long. The key is sampled on the first byte of each blob.
// One byte is accepted every cycle unless the result register stalls the
// input. A byte passes an input register, the parse update, and, for the last
// byte of a blob, the result register, which holds the result word. Only the
// result register can stall the input, and only when a blob's last byte meets
// a held result that is not being taken.
module tlv_key_scanner_top (
    input  wire   i_clk,
    input  wire   i_rst_n,
    tks_in_if.sink   i_in,
    tks_out_if.source o_out
);
    import tks_pkg::*;

    t_in_word in_word;
    t_in_word st_word;
    t_result  parse_result;
    t_result  out_result;
    logic     st_valid;
    logic     st_fire;
    logic     out_free;
    logic     in_ready;
    logic     out_valid;

    // Pack the input channel
    assign in_word.data_byte  = i_in.data_byte;
    assign in_word.search_key = i_in.search_key;
    assign in_word.blob_end   = i_in.blob_end;

    // Move a byte into the parser unless it ends a blob and the result is stalled
    assign st_fire = st_valid && (!st_word.blob_end || out_free);

    tks_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_word  (in_word),
        .i_take  (st_fire),
        .o_ready (in_ready),
        .o_valid (st_valid),
        .o_word  (st_word)
    );

    tks_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (st_fire),
        .i_word   (st_word),
        .o_result (parse_result)
    );

    tks_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (st_fire && st_word.blob_end),
        .i_result (parse_result),
        .i_ready  (o_out.ready),
        .o_free   (out_free),
        .o_valid  (out_valid),
        .o_result (out_result)
    );

    // Drive the channels
    assign i_in.ready          = in_ready;
    assign o_out.valid         = out_valid;
    assign o_out.status        = out_result.status;
    assign o_out.record_offset = out_result.record_offset;
    assign o_out.value_length  = out_result.value_length;
endmodule

`default_nettype wire
